// File: src/top_k_min_heap_select_defines.svh
// Assertion macros used by the checker file.
`ifndef TOP_K_MIN_HEAP_SELECT_DEFINES_SVH
`define TOP_K_MIN_HEAP_SELECT_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define TKH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define TKH_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/tkh_pkg.sv
`timescale 1ns / 1ps

package tkh_pkg;

  localparam int SCORE_W   = 32;
  localparam int TAG_W     = 32;
  localparam int ENTRY_W   = SCORE_W + TAG_W;
  localparam int KEEP_W    = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd10;

  localparam logic FUNC_PUSH    = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic        [TAG_W-1:0]   tag;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ROOT_RD,
    ST_ROOT_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_EX_RD,
    ST_EX_POP,
    ST_EM_RD,
    ST_EM_LD,
    ST_EMPTY
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_UP_START,
    OP_UP_MOVE,
    OP_UP_FINAL,
    OP_DN_START,
    OP_DN_MOVE,
    OP_DN_FINAL,
    OP_EX_START,
    OP_EX_POP,
    OP_EM_LOAD,
    OP_EM_EMPTY
  } op_t;

  // Read address selection for the two heap RAM ports
  typedef enum logic [1:0] {
    RS_PARENT,
    RS_CHILD,
    RS_ROOT_LAST,
    RS_EMIT
  } rsel_t;

  typedef struct packed {
    op_t   op;
    rsel_t rsel;
  } cmd_t;

  typedef struct packed {
    logic cap_zero;
    logic has_room;
    logic fill_zero;
    logic fill_one;
    logic up_move;
    logic root_less;
    logic dn_move;
    logic em_last;
    logic out_free;
  } stat_t;

endpackage

// File: src/tkh_ram.sv
`timescale 1ns / 1ps

module tkh_ram #(
  parameter int WIDTH = tkh_pkg::ENTRY_W,
  parameter int DEPTH = tkh_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_a_r <= mem_r[raddr_a];
    rd_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// File: src/tkh_ctrl.sv
`timescale 1ns / 1ps

module tkh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_func,
  output logic           in_stall,
  input  tkh_pkg::stat_t stat,
  output tkh_pkg::cmd_t  cmd
);

  tkh_pkg::state_t state_r, state_nxt;
  logic            ex_mode_r, ex_mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tkh_pkg::ST_IDLE;
      ex_mode_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ex_mode_r <= ex_mode_nxt;
    end
  end

  // extract runs share the sift-down states with pushes
  always_comb begin
    ex_mode_nxt = ex_mode_r;
    if (state_r == tkh_pkg::ST_IDLE && in_valid) begin
      ex_mode_nxt = (in_func == tkh_pkg::FUNC_EXTRACT);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tkh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_func == tkh_pkg::FUNC_PUSH) begin
            if (stat.cap_zero) begin
              state_nxt = tkh_pkg::ST_IDLE;
            end else if (stat.has_room) begin
              state_nxt = tkh_pkg::ST_UP_RD;
            end else begin
              state_nxt = tkh_pkg::ST_ROOT_RD;
            end
          end else if (stat.fill_zero) begin
            state_nxt = tkh_pkg::ST_EMPTY;
          end else begin
            state_nxt = tkh_pkg::ST_EX_RD;
          end
        end
      end
      tkh_pkg::ST_UP_RD:    state_nxt = tkh_pkg::ST_UP_CMP;
      tkh_pkg::ST_UP_CMP:   state_nxt = stat.up_move ? tkh_pkg::ST_UP_RD : tkh_pkg::ST_IDLE;
      tkh_pkg::ST_ROOT_RD:  state_nxt = tkh_pkg::ST_ROOT_CMP;
      tkh_pkg::ST_ROOT_CMP: state_nxt = stat.root_less ? tkh_pkg::ST_DN_RD : tkh_pkg::ST_IDLE;
      tkh_pkg::ST_DN_RD:    state_nxt = tkh_pkg::ST_DN_CMP;
      tkh_pkg::ST_DN_CMP: begin
        if (stat.dn_move) begin
          state_nxt = tkh_pkg::ST_DN_RD;
        end else if (ex_mode_r) begin
          state_nxt = tkh_pkg::ST_EX_RD;
        end else begin
          state_nxt = tkh_pkg::ST_IDLE;
        end
      end
      tkh_pkg::ST_EX_RD:    state_nxt = tkh_pkg::ST_EX_POP;
      tkh_pkg::ST_EX_POP:   state_nxt = stat.fill_one ? tkh_pkg::ST_EM_RD : tkh_pkg::ST_DN_RD;
      tkh_pkg::ST_EM_RD:    state_nxt = tkh_pkg::ST_EM_LD;
      tkh_pkg::ST_EM_LD: begin
        if (stat.out_free) begin
          state_nxt = stat.em_last ? tkh_pkg::ST_IDLE : tkh_pkg::ST_EM_RD;
        end
      end
      tkh_pkg::ST_EMPTY: begin
        if (stat.out_free) begin
          state_nxt = tkh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tkh_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != tkh_pkg::ST_IDLE);
    cmd.op   = tkh_pkg::OP_NONE;
    cmd.rsel = tkh_pkg::RS_ROOT_LAST;
    unique case (state_r)
      tkh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_func == tkh_pkg::FUNC_PUSH) begin
            if (stat.cap_zero) begin
              cmd.op = tkh_pkg::OP_NONE;
            end else if (stat.has_room) begin
              cmd.op = tkh_pkg::OP_UP_START;
            end else begin
              cmd.op = tkh_pkg::OP_LATCH;
            end
          end else if (!stat.fill_zero) begin
            cmd.op = tkh_pkg::OP_EX_START;
          end
        end
      end
      tkh_pkg::ST_UP_RD: cmd.rsel = tkh_pkg::RS_PARENT;
      tkh_pkg::ST_UP_CMP: begin
        cmd.rsel = tkh_pkg::RS_PARENT;
        cmd.op   = stat.up_move ? tkh_pkg::OP_UP_MOVE : tkh_pkg::OP_UP_FINAL;
      end
      tkh_pkg::ST_ROOT_RD: cmd.rsel = tkh_pkg::RS_ROOT_LAST;
      tkh_pkg::ST_ROOT_CMP: begin
        cmd.op = stat.root_less ? tkh_pkg::OP_DN_START : tkh_pkg::OP_NONE;
      end
      tkh_pkg::ST_DN_RD: cmd.rsel = tkh_pkg::RS_CHILD;
      tkh_pkg::ST_DN_CMP: begin
        cmd.rsel = tkh_pkg::RS_CHILD;
        cmd.op   = stat.dn_move ? tkh_pkg::OP_DN_MOVE : tkh_pkg::OP_DN_FINAL;
      end
      tkh_pkg::ST_EX_RD:  cmd.rsel = tkh_pkg::RS_ROOT_LAST;
      tkh_pkg::ST_EX_POP: cmd.op   = tkh_pkg::OP_EX_POP;
      tkh_pkg::ST_EM_RD:  cmd.rsel = tkh_pkg::RS_EMIT;
      tkh_pkg::ST_EM_LD: begin
        cmd.rsel = tkh_pkg::RS_EMIT;
        cmd.op   = stat.out_free ? tkh_pkg::OP_EM_LOAD : tkh_pkg::OP_NONE;
      end
      tkh_pkg::ST_EMPTY: begin
        cmd.op = stat.out_free ? tkh_pkg::OP_EM_EMPTY : tkh_pkg::OP_NONE;
      end
      default: cmd.op = tkh_pkg::OP_NONE;
    endcase
  end

endmodule

// File: src/tkh_dp.sv
`timescale 1ns / 1ps

module tkh_dp #(
  parameter int DEPTH = tkh_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tkh_pkg::cmd_t                     cmd,
  output tkh_pkg::stat_t                    stat,
  input  logic signed [tkh_pkg::SCORE_W-1:0] in_score,
  input  logic [tkh_pkg::TAG_W-1:0]         in_tag,
  input  logic                              cfg_we,
  input  logic [tkh_pkg::KEEP_W-1:0]        cfg_keep_count,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic signed [tkh_pkg::SCORE_W-1:0] out_score,
  output logic [tkh_pkg::TAG_W-1:0]         out_tag,
  output logic                              out_last,
  output logic                              out_empty_res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = AW + 2;
  localparam int EW = (CW > tkh_pkg::KEEP_W) ? CW : tkh_pkg::KEEP_W;

  // control state
  logic [tkh_pkg::KEEP_W-1:0] keep_r, keep_nxt;
  logic [CW-1:0]              fill_r, fill_nxt;
  logic                       out_valid_r, out_valid_nxt;
  // working registers
  logic [CW-1:0]              size_r, size_nxt;
  logic [CW-1:0]              emit_n_r, emit_n_nxt;
  logic [AW-1:0]              pos_r, pos_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  tkh_pkg::entry_t            cur_r, cur_nxt;
  tkh_pkg::entry_t            out_r, out_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_empty_r, out_empty_nxt;

  tkh_pkg::entry_t            in_ent;
  tkh_pkg::entry_t            rd_a, rd_b;
  logic [tkh_pkg::ENTRY_W-1:0] rd_a_raw, rd_b_raw;
  logic                       we;
  logic [AW-1:0]              waddr;
  tkh_pkg::entry_t            wdata;
  logic [AW-1:0]              raddr_a, raddr_b;

  logic [EW-1:0]              keep_x, cap_x;
  logic [CW-1:0]              cap;
  logic [CW-1:0]              fill_m1;
  logic [AW-1:0]              pos_m1, parent;
  logic [XW-1:0]              l_x, r_x, size_x;
  logic                       l_lt, r_lt;
  logic signed [tkh_pkg::SCORE_W-1:0] best_score;
  tkh_pkg::entry_t            dn_child;
  logic [AW-1:0]              dn_pos;
  logic                       em_last;

  assign in_ent.score = in_score;
  assign in_ent.tag   = in_tag;
  assign rd_a         = tkh_pkg::entry_t'(rd_a_raw);
  assign rd_b         = tkh_pkg::entry_t'(rd_b_raw);

  // effective capacity: smaller of keep_count and DEPTH
  assign keep_x  = EW'(keep_r);
  assign cap_x   = (keep_x < EW'(DEPTH)) ? keep_x : EW'(DEPTH);
  assign cap     = cap_x[CW-1:0];
  assign fill_m1 = fill_r - CW'(1);

  assign pos_m1 = pos_r - AW'(1);
  assign parent = (pos_r == '0) ? '0 : (pos_m1 >> 1);

  // children of pos and choice of the smaller one (left wins ties)
  assign l_x        = (XW'(pos_r) << 1) | XW'(1);
  assign r_x        = l_x + XW'(1);
  assign size_x     = XW'(size_r);
  assign l_lt       = (l_x < size_x) && ($signed(rd_a.score) < $signed(cur_r.score));
  assign best_score = l_lt ? rd_a.score : cur_r.score;
  assign r_lt       = (r_x < size_x) && ($signed(rd_b.score) < $signed(best_score));
  assign dn_child   = r_lt ? rd_b : rd_a;
  assign dn_pos     = r_lt ? r_x[AW-1:0] : l_x[AW-1:0];

  assign em_last = (CW'(idx_r) == (emit_n_r - CW'(1)));

  always_comb begin
    stat.cap_zero  = (keep_r == '0);
    stat.has_room  = (fill_r < cap);
    stat.fill_zero = (fill_r == '0);
    stat.fill_one  = (fill_r == CW'(1));
    stat.up_move   = (pos_r != '0) && ($signed(cur_r.score) < $signed(rd_a.score));
    stat.root_less = ($signed(rd_a.score) < $signed(cur_r.score));
    stat.dn_move   = l_lt | r_lt;
    stat.em_last   = em_last;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    unique case (cmd.rsel)
      tkh_pkg::RS_PARENT: raddr_a = parent;
      tkh_pkg::RS_CHILD: begin
        raddr_a = l_x[AW-1:0];
        raddr_b = r_x[AW-1:0];
      end
      tkh_pkg::RS_ROOT_LAST: raddr_b = fill_m1[AW-1:0];
      tkh_pkg::RS_EMIT:      raddr_a = idx_r;
      default:               raddr_a = '0;
    endcase
  end

  assign keep_nxt = cfg_we ? cfg_keep_count : keep_r;

  always_comb begin
    fill_nxt      = fill_r;
    size_nxt      = size_r;
    emit_n_nxt    = emit_n_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    waddr         = pos_r;
    wdata         = cur_r;
    unique case (cmd.op)
      tkh_pkg::OP_NONE: ;
      tkh_pkg::OP_LATCH: cur_nxt = in_ent;
      tkh_pkg::OP_UP_START: begin
        cur_nxt  = in_ent;
        pos_nxt  = fill_r[AW-1:0];
        fill_nxt = fill_r + CW'(1);
      end
      tkh_pkg::OP_UP_MOVE: begin
        we      = 1'b1;
        wdata   = rd_a;
        pos_nxt = parent;
      end
      tkh_pkg::OP_UP_FINAL: we = 1'b1;
      tkh_pkg::OP_DN_START: begin
        pos_nxt  = '0;
        size_nxt = fill_r;
      end
      tkh_pkg::OP_DN_MOVE: begin
        we      = 1'b1;
        wdata   = dn_child;
        pos_nxt = dn_pos;
      end
      tkh_pkg::OP_DN_FINAL: we = 1'b1;
      tkh_pkg::OP_EX_START: begin
        emit_n_nxt = fill_r;
        idx_nxt    = '0;
      end
      tkh_pkg::OP_EX_POP: begin
        // popped root parks in the slot just freed: heapsort in place
        we       = 1'b1;
        waddr    = fill_m1[AW-1:0];
        wdata    = rd_a;
        cur_nxt  = rd_b;
        fill_nxt = fill_m1;
        size_nxt = fill_m1;
        pos_nxt  = '0;
      end
      tkh_pkg::OP_EM_LOAD: begin
        out_nxt       = rd_a;
        out_last_nxt  = em_last;
        out_empty_nxt = 1'b0;
        out_valid_nxt = 1'b1;
        idx_nxt       = idx_r + AW'(1);
      end
      tkh_pkg::OP_EM_EMPTY: begin
        out_nxt       = '0;
        out_last_nxt  = 1'b1;
        out_empty_nxt = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r      <= tkh_pkg::KEEP_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      keep_r      <= keep_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r      <= size_nxt;
    emit_n_r    <= emit_n_nxt;
    pos_r       <= pos_nxt;
    idx_r       <= idx_nxt;
    cur_r       <= cur_nxt;
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  tkh_ram #(
    .WIDTH (tkh_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_heap_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a_raw),
    .rdata_b (rd_b_raw)
  );

  assign out_valid     = out_valid_r;
  assign out_score     = out_r.score;
  assign out_tag       = out_r.tag;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

endmodule

// File: src/top_k_min_heap_select.sv
// Push: dropped at keep_count 0 and when it does not beat a full heap's root; else it sifts
//   up from the tail into a heap with room, or down from the root in place of the root.
// Extract of N held items: each pop but the last is followed by a sift-down, then the
//   results are transferred in order; an empty extract shows a single empty result.
// One item is worked at a time; the heap RAM is read through registered read ports.
// Reset (rst_n low, synchronous): heap empty, keep_count 10, no result pending.
`timescale 1ns / 1ps

// Top-k selection with a bounded binary min-heap.
// The heap lives in a 1-write / 2-read RAM of {score, tag} entries. The root is the
// weakest item kept, so a push into a full heap only has to beat the root.
// Sifts move a hole rather than swapping: the travelling item sits in a register and
// is written once, where it settles.
// Extract is an in-place heapsort: each popped root is stored in the slot freed at the
// tail, so after the last pop the RAM holds the items best-first from index 0 and the
// results are read out in address order. The output register decouples the result
// transfer from the engine.
module top_k_min_heap_select #(
  parameter int DEPTH = tkh_pkg::DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic signed [tkh_pkg::SCORE_W-1:0] in_score,
  input  logic [tkh_pkg::TAG_W-1:0]          in_tag,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tkh_pkg::SCORE_W-1:0] out_score,
  output logic [tkh_pkg::TAG_W-1:0]          out_tag,
  output logic                               out_last,
  output logic                               out_empty_res,
  // configuration
  input  logic                               cfg_we,
  input  logic [tkh_pkg::KEEP_W-1:0]         cfg_keep_count
);

  tkh_pkg::cmd_t  cmd;
  tkh_pkg::stat_t stat;

  // sequencer: picks push / extract flow and steps the sift loops
  tkh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // heap RAM, fill count, sift position and the result register
  tkh_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_score       (in_score),
    .in_tag         (in_tag),
    .cfg_we         (cfg_we),
    .cfg_keep_count (cfg_keep_count),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_score      (out_score),
    .out_tag        (out_tag),
    .out_last       (out_last),
    .out_empty_res  (out_empty_res)
  );

endmodule

// File: src/tkh_checker.sv
`timescale 1ns / 1ps
`include "top_k_min_heap_select_defines.svh"

module tkh_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               in_func,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [tkh_pkg::SCORE_W-1:0] out_score,
  input logic [tkh_pkg::TAG_W-1:0]          out_tag,
  input logic                               out_last,
  input logic                               out_empty_res
);

  `TKH_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_score) && $stable(out_tag) && $stable(out_last) && $stable(out_empty_res), "stalled result changed")
  `TKH_ASSERT(a_empty_res, clk, rst_n, out_valid && out_empty_res |-> out_last && (out_score == '0) && (out_tag == '0), "empty result malformed")
  `TKH_ASSERT(a_extract_busy, clk, rst_n, in_valid && !in_stall && (in_func == tkh_pkg::FUNC_EXTRACT) |=> in_stall, "extract transfer not followed by stall")
  `TKH_ASSERT(a_push_silent, clk, rst_n, in_valid && !in_stall && (in_func == tkh_pkg::FUNC_PUSH) && !out_valid |=> !out_valid, "push produced a result")
  `TKH_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid && !in_stall, "not idle after reset")

endmodule

bind top_k_min_heap_select tkh_checker u_tkh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_func       (in_func),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_score     (out_score),
  .out_tag       (out_tag),
  .out_last      (out_last),
  .out_empty_res (out_empty_res)
);
